@@ rtl/pil_pkg.sv @@
package pil_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned ValW        = 32;

  typedef logic [1:0] pil_op_t;
  localparam pil_op_t OP_HOLD   = 2'd0;
  localparam pil_op_t OP_INSERT = 2'd1;
  localparam pil_op_t OP_FWD    = 2'd2;
  localparam pil_op_t OP_REV    = 2'd3;

  typedef logic [1:0] pil_status_t;
  localparam pil_status_t ST_OK      = 2'd0;
  localparam pil_status_t ST_INVALID = 2'd1;
  localparam pil_status_t ST_FULL    = 2'd2;

endpackage

@@ rtl/pil_cell.sv @@
module pil_cell import pil_pkg::*; #(
  parameter int unsigned CntW  = 5,
  parameter int unsigned Index = 0
) (
  input  logic                   clk_i,
  input  pil_op_t                op_i,
  input  logic [CntW-1:0]        pos_i,
  input  logic [CntW-1:0]        len_i,
  input  logic signed [ValW-1:0] new_i,
  input  logic signed [ValW-1:0] prev_i,
  input  logic signed [ValW-1:0] next_i,
  output logic signed [ValW-1:0] val_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(Index);

  logic signed [ValW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    case (op_i)
      OP_INSERT: begin
        if (pos_i == IdxC) begin
          val_d = new_i;
        end else if (IdxC > pos_i && IdxC <= len_i) begin
          val_d = prev_i;
        end
      end
      OP_FWD:  val_d = next_i;
      OP_REV:  val_d = prev_i;
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

@@ rtl/positional_insert_list.sv @@
// A rejected insert gives its single result in the cycle after the request.
// A valid insert first shifts the cell ring, then streams 2*length results at one
// per cycle, while the output is not stalled, from the ring's fixed head and tail taps.
// A new request is stalled until the sequencer has issued every result of the last insert.
// Reset clears the length, sequencer and output valid; cell contents are not reset.
module positional_insert_list import pil_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             position_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic                   direction_o,
  output logic signed [ValW-1:0] entry_o,
  output logic                   is_last_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapC = CntW'(Capacity);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FWD  = 2'd1;
  localparam logic [1:0] S_REV  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] len_q, len_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic                   out_valid_q, out_valid_d;
  pil_status_t            status_q, status_d;
  logic                   dir_q, dir_d;
  logic signed [ValW-1:0] entry_q, entry_d;
  logic                   last_q, last_d;

  logic signed [ValW-1:0] cell_val [Capacity];
  pil_op_t                op;
  logic                   accept, out_free, pos_ok, full;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) | ~out_free;
  assign accept     = in_valid_i & ~in_stall_o;
  assign pos_ok     = {1'b0, position_i} <= 9'(len_q);
  assign full       = len_q == CapC;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    pil_cell #(
      .CntW  (CntW),
      .Index (g)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .pos_i  (CntW'(position_i)),
      .len_i  (len_q),
      .new_i  (value_i),
      .prev_i (cell_val[(g + Capacity - 1) % Capacity]),
      .next_i (cell_val[(g + 1) % Capacity]),
      .val_o  (cell_val[g])
    );
  end

  always_comb begin
    op          = OP_HOLD;
    state_d     = state_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    status_d    = status_q;
    dir_d       = dir_q;
    entry_d     = entry_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!pos_ok || full) begin
            out_valid_d = 1'b1;
            status_d    = pos_ok ? ST_FULL : ST_INVALID;
            dir_d       = 1'b0;
            entry_d     = '0;
            last_d      = 1'b1;
          end else begin
            op      = OP_INSERT;
            len_d   = len_q + 1'b1;
            cnt_d   = '0;
            state_d = S_FWD;
          end
        end
      end
      S_FWD: begin
        if (out_free) begin
          op          = OP_FWD;
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          dir_d       = 1'b0;
          entry_d     = cell_val[0];
          last_d      = 1'b0;
          if (cnt_q + 1'b1 == len_q) begin
            cnt_d   = '0;
            state_d = S_REV;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_REV: begin
        if (out_free) begin
          op          = OP_REV;
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          dir_d       = 1'b1;
          entry_d     = cell_val[Capacity-1];
          last_d      = (cnt_q + 1'b1 == len_q);
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q + 1'b1 == len_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    dir_q    <= dir_d;
    entry_q  <= entry_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign direction_o = dir_q;
  assign entry_o     = entry_q;
  assign is_last_o   = last_q;

endmodule
